// File: hdl/pwca_pkg.sv
// Package: shared types, status codes and queue ordering for the capacity allocator.
package pwca_pkg;

   typedef struct packed {
      logic [7:0]  gprio;
      logic [7:0]  sprio;
      logic [15:0] amount;
      logic [7:0]  id;
   } entry_type;

   typedef enum logic [0:0] {
      OP_REQUEST = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_GRANTED     = 3'd0,
      ST_QUEUED      = 3'd1,
      ST_QUEUE_FULL  = 3'd2,
      ST_RELEASED    = 3'd3,
      ST_REL_GRANTED = 3'd4,
      ST_REL_OVERRUN = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE   = 4'b0001,
      FSM_INSERT = 4'b0010,
      FSM_SCAN   = 4'b0100,
      FSM_SHIFT  = 4'b1000
   } fsm_type;

   function automatic logic ranks_ahead(input entry_type a, input entry_type b);
      ranks_ahead = {a.sprio, a.gprio} > {b.sprio, b.gprio};
   endfunction

endpackage

// File: hdl/priority_wait_capacity_allocator.sv
// Top level: capacity allocator with a priority-ordered wait queue held in memory.
//
//   channel  direction  tdata fields (low bit up)                        tuser
//   req      in         requester_id, amount, sprio, gprio (40 bits)     operation
//   rsp      out        granted_id, granted_amount, free, waiting (48)   status
//   csr      in         total_capacity (16 bits), write enable          -
//
// Immediate grants, queue-full answers, release overruns and work on an empty queue
// are decided in the accept cycle; the result shows on rsp from the next cycle.
// After the accept cycle an insert walks up from the tail, moving each entry it passes
// back one place; a release scans the waiters from the head and closes the granted gap.
// Synchronous reset clears the queue length and loads free and total capacity with 16.
// A result held by rsp_tready blocks the next transfer on req.
module priority_wait_capacity_allocator #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // requester_id, amount, service_priority, general_priority
   input  logic [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // granted_id, granted_amount, free_units, waiting_count
   output logic [2:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   pwca_pkg::fsm_type   state_ff, state_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [15:0]         free_ff, free_in;
   logic [15:0]         total_ff, total_in;
   pwca_pkg::entry_type newent_ff, newent_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_gid_ff, rsp_gid_in;
   logic [15:0]         rsp_gamt_ff, rsp_gamt_in;
   logic [15:0]         rsp_free_ff, rsp_free_in;
   logic [4:0]          rsp_wc_ff, rsp_wc_in;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   pwca_pkg::entry_type mem_wdata;
   pwca_pkg::entry_type mem_rdata;

   pwca_pkg::entry_type req_entry;
   logic                req_xfer;
   logic                fin;
   logic [16:0]         sum;

   pwca_wait_mem #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_wait_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_entry  = pwca_pkg::entry_type'(req_tdata);
   assign req_tready = (state_ff == pwca_pkg::FSM_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign sum        = {1'b0, free_ff} + {1'b0, req_entry.amount};

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      len_in        = len_ff;
      free_in       = free_ff;
      total_in      = total_ff;
      newent_in     = newent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_gid_in    = rsp_gid_ff;
      rsp_gamt_in   = rsp_gamt_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_wc_in     = rsp_wc_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'(ptr_ff);
      mem_wdata     = newent_ff;
      mem_raddr     = '0;
      fin           = 1'b0;

      case (state_ff)
         pwca_pkg::FSM_IDLE: begin
            mem_raddr = (req_tuser[0] == pwca_pkg::OP_RELEASE) ? '0 : AW'(len_ff - CW'(1));
            if (req_xfer) begin
               newent_in   = req_entry;
               rsp_gid_in  = '0;
               rsp_gamt_in = '0;
               if (req_tuser[0] == pwca_pkg::OP_REQUEST) begin
                  if (free_ff >= req_entry.amount) begin
                     free_in       = free_ff - req_entry.amount;
                     fin           = 1'b1;
                     rsp_status_in = pwca_pkg::ST_GRANTED;
                  end else if (len_ff >= CW'(QUEUE_DEPTH)) begin
                     fin           = 1'b1;
                     rsp_status_in = pwca_pkg::ST_QUEUE_FULL;
                  end else if (len_ff == '0) begin
                     mem_we        = 1'b1;
                     mem_waddr     = '0;
                     mem_wdata     = req_entry;
                     len_in        = CW'(1);
                     fin           = 1'b1;
                     rsp_status_in = pwca_pkg::ST_QUEUED;
                  end else begin
                     ptr_in   = len_ff;
                     state_in = pwca_pkg::FSM_INSERT;
                  end
               end else begin
                  if (sum > {1'b0, total_ff}) begin
                     fin           = 1'b1;
                     rsp_status_in = pwca_pkg::ST_REL_OVERRUN;
                  end else begin
                     free_in = sum[15:0];
                     if (len_ff == '0) begin
                        fin           = 1'b1;
                        rsp_status_in = pwca_pkg::ST_RELEASED;
                     end else begin
                        ptr_in   = '0;
                        state_in = pwca_pkg::FSM_SCAN;
                     end
                  end
               end
            end
         end
         pwca_pkg::FSM_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_ff);
            if (ptr_ff != '0 && pwca_pkg::ranks_ahead(newent_ff, mem_rdata)) begin
               mem_wdata = mem_rdata;
               mem_raddr = AW'(ptr_ff - CW'(2));
               ptr_in    = ptr_ff - CW'(1);
            end else begin
               mem_wdata     = newent_ff;
               len_in        = len_ff + CW'(1);
               fin           = 1'b1;
               rsp_status_in = pwca_pkg::ST_QUEUED;
               state_in      = pwca_pkg::FSM_IDLE;
            end
         end
         pwca_pkg::FSM_SCAN: begin
            mem_raddr = AW'(ptr_ff + CW'(1));
            if (mem_rdata.amount <= free_ff) begin
               free_in     = free_ff - mem_rdata.amount;
               rsp_gid_in  = mem_rdata.id;
               rsp_gamt_in = mem_rdata.amount;
               if ((ptr_ff + CW'(1)) < len_ff) begin
                  state_in = pwca_pkg::FSM_SHIFT;
               end else begin
                  len_in        = len_ff - CW'(1);
                  fin           = 1'b1;
                  rsp_status_in = pwca_pkg::ST_REL_GRANTED;
                  state_in      = pwca_pkg::FSM_IDLE;
               end
            end else if ((ptr_ff + CW'(1)) < len_ff) begin
               ptr_in = ptr_ff + CW'(1);
            end else begin
               fin           = 1'b1;
               rsp_status_in = pwca_pkg::ST_RELEASED;
               state_in      = pwca_pkg::FSM_IDLE;
            end
         end
         pwca_pkg::FSM_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_ff);
            mem_wdata = mem_rdata;
            mem_raddr = AW'(ptr_ff + CW'(2));
            if ((ptr_ff + CW'(2)) < len_ff) begin
               ptr_in = ptr_ff + CW'(1);
            end else begin
               len_in        = len_ff - CW'(1);
               fin           = 1'b1;
               rsp_status_in = pwca_pkg::ST_REL_GRANTED;
               state_in      = pwca_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = pwca_pkg::FSM_IDLE;
         end
      endcase

      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_free_in  = free_in;
         rsp_wc_in    = 5'(len_in);
      end

      if (csr_wr_en) begin
         total_in = csr_wr_data;
         free_in  = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwca_pkg::FSM_IDLE;
         len_ff       <= '0;
         free_ff      <= 16'd16;
         total_ff     <= 16'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      newent_ff     <= newent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gid_ff    <= rsp_gid_in;
      rsp_gamt_ff   <= rsp_gamt_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_wc_ff     <= rsp_wc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_wc_ff, rsp_free_ff, rsp_gamt_ff, rsp_gid_ff};

endmodule

// File: hdl/pwca_wait_mem.sv
// Wait queue storage: one write port, one registered read port.
module pwca_wait_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pwca_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output pwca_pkg::entry_type rd_data
);

   pwca_pkg::entry_type mem [DEPTH];
   pwca_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pwca_checker.sv
// Port checker for the capacity allocator, bound to the top level.
module pwca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= pwca_pkg::ST_REL_OVERRUN)
      else $error("status code out of range");

   a_grant_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != pwca_pkg::ST_REL_GRANTED |-> rsp_tdata[23:0] == 24'd0)
      else $error("waiter fields set without a waiter grant");

   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while a result is held");

endmodule

bind priority_wait_capacity_allocator pwca_checker u_pwca_checker (.*);

// File: tb/tb_priority_wait_capacity_allocator.sv
// Testbench: stimulus and response checking for the capacity allocator.
module tb_priority_wait_capacity_allocator;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1550;
   localparam int PHASES       = 5;
   // a zero entry stands for a random capacity
   localparam logic [15:0] PHASE_CAPACITY [PHASES] = '{16'hFFFF, 16'd1, 16'd40, 16'd0, 16'd16};

   typedef struct packed {
      pwca_pkg::status_type status;
      logic [7:0]           gid;
      logic [15:0]          gamt;
      logic [15:0]          free;
      logic [4:0]           waiting;
   } outcome_type;

   typedef struct {
      pwca_pkg::op_type op;
      logic [7:0]       id;
      logic [15:0]      amount;
      logic [7:0]       sprio;
      logic [7:0]       gprio;
      int               repeats;
      bit               typed;
      outcome_type      outcome;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // requester_id, amount, service_priority, general_priority
   logic [0:0]  req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // granted_id, granted_amount, free_units, waiting_count
   logic [2:0]  rsp_tuser;   // status
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   logic [15:0]         pool_total;
   logic [15:0]         pool_free;
   pwca_pkg::entry_type waiters[$];
   outcome_type         pending_outcomes[$];
   bit                  cur_typed;
   outcome_type         cur_outcome;
   int                  errors;
   int                  responses;
   int                  burst_left;

   row_type directed_rows [19] = '{
      '{pwca_pkg::OP_REQUEST, 8'h01, 16'd0,     8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_GRANTED,     8'd0, 16'd0, 16'd16, 5'd0}},
      '{pwca_pkg::OP_REQUEST, 8'h02, 16'd16,    8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_GRANTED,     8'd0, 16'd0, 16'd0,  5'd0}},
      '{pwca_pkg::OP_RELEASE, 8'h02, 16'd17,    8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_REL_OVERRUN, 8'd0, 16'd0, 16'd0,  5'd0}},
      '{pwca_pkg::OP_RELEASE, 8'h02, 16'hFFFF,  8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_REL_OVERRUN, 8'd0, 16'd0, 16'd0,  5'd0}},
      '{pwca_pkg::OP_REQUEST, 8'h03, 16'd5,     8'd10,  8'd0,   1,  1'b1,
        '{pwca_pkg::ST_QUEUED,      8'd0, 16'd0, 16'd0,  5'd1}},
      '{pwca_pkg::OP_REQUEST, 8'h04, 16'd3,     8'd20,  8'd0,   1,  1'b1,
        '{pwca_pkg::ST_QUEUED,      8'd0, 16'd0, 16'd0,  5'd2}},
      '{pwca_pkg::OP_REQUEST, 8'h05, 16'd3,     8'd20,  8'd5,   1,  1'b1,
        '{pwca_pkg::ST_QUEUED,      8'd0, 16'd0, 16'd0,  5'd3}},
      '{pwca_pkg::OP_REQUEST, 8'h06, 16'd3,     8'd20,  8'd5,   1,  1'b1,
        '{pwca_pkg::ST_QUEUED,      8'd0, 16'd0, 16'd0,  5'd4}},
      '{pwca_pkg::OP_RELEASE, 8'h09, 16'd0,     8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_RELEASED,    8'd0, 16'd0, 16'd0,  5'd4}},
      '{pwca_pkg::OP_RELEASE, 8'h09, 16'd4,     8'd0,   8'd0,   1,  1'b0, '0},
      '{pwca_pkg::OP_REQUEST, 8'hFF, 16'hFFFF,  8'hFF,  8'hFF,  1,  1'b0, '0},
      '{pwca_pkg::OP_REQUEST, 8'h00, 16'd0,     8'hFF,  8'hFF,  1,  1'b0, '0},
      '{pwca_pkg::OP_RELEASE, 8'h0A, 16'd12,    8'd0,   8'd0,   1,  1'b0, '0},
      '{pwca_pkg::OP_REQUEST, 8'h80, 16'h8000,  8'd0,   8'd0,   13, 1'b0, '0},
      '{pwca_pkg::OP_REQUEST, 8'h7F, 16'h7FFF,  8'hFF,  8'd0,   1,  1'b1,
        '{pwca_pkg::ST_QUEUE_FULL,  8'd0, 16'd0, 16'd10, 5'd16}},
      '{pwca_pkg::OP_REQUEST, 8'h07, 16'd10,    8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_GRANTED,     8'd0, 16'd0, 16'd0,  5'd16}},
      '{pwca_pkg::OP_RELEASE, 8'h0B, 16'd6,     8'd0,   8'd0,   1,  1'b1,
        '{pwca_pkg::ST_REL_GRANTED, 8'h04, 16'd3, 16'd3, 5'd15}},
      '{pwca_pkg::OP_RELEASE, 8'h0C, 16'd13,    8'd0,   8'd0,   1,  1'b0, '0},
      '{pwca_pkg::OP_RELEASE, 8'h0D, 16'd6,     8'd0,   8'd0,   1,  1'b0, '0}
   };

   priority_wait_capacity_allocator #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic outcome_type allocate(input pwca_pkg::op_type op,
                                            input pwca_pkg::entry_type item);
      outcome_type res;
      logic [16:0] sum;
      int          pos;
      int          hit;
      res = '0;
      if (op == pwca_pkg::OP_REQUEST) begin
         if (pool_free >= item.amount) begin
            pool_free -= item.amount;
            res.status = pwca_pkg::ST_GRANTED;
         end else if (waiters.size() >= QUEUE_DEPTH) begin
            res.status = pwca_pkg::ST_QUEUE_FULL;
         end else begin
            pos = waiters.size();
            while (pos > 0 && {item.sprio, item.gprio} >
                              {waiters[pos-1].sprio, waiters[pos-1].gprio})
               pos--;
            waiters.insert(pos, item);
            res.status = pwca_pkg::ST_QUEUED;
         end
      end else begin
         sum = {1'b0, pool_free} + item.amount;
         if (sum > {1'b0, pool_total}) begin
            res.status = pwca_pkg::ST_REL_OVERRUN;
         end else begin
            pool_free = sum[15:0];
            res.status = pwca_pkg::ST_RELEASED;
            hit = -1;
            for (int i = 0; i < waiters.size(); i++)
               if (hit < 0 && waiters[i].amount <= pool_free) hit = i;
            if (hit >= 0) begin
               res.status = pwca_pkg::ST_REL_GRANTED;
               res.gid = waiters[hit].id;
               res.gamt = waiters[hit].amount;
               pool_free -= waiters[hit].amount;
               waiters.delete(hit);
            end
         end
      end
      res.free = pool_free;
      res.waiting = 5'(waiters.size());
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         pool_total = 16'd16;
         pool_free = 16'd16;
         waiters.delete();
      end else begin
         if (csr_wr_en) begin
            pool_total = csr_wr_data;
            pool_free = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            want = allocate(pwca_pkg::op_type'(req_tuser), pwca_pkg::entry_type'(req_tdata));
            if (cur_typed) want = cur_outcome;
            pending_outcomes = {pending_outcomes, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            responses++;
            got = '{status: pwca_pkg::status_type'(rsp_tuser), gid: rsp_tdata[7:0],
                    gamt: rsp_tdata[23:8], free: rsp_tdata[39:24], waiting: rsp_tdata[44:40]};
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = pending_outcomes.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                  errors++;
               end
               if (got.gid !== want.gid) begin
                  $display("%0t: granted_id expected %0d actual %0d", $time, want.gid, got.gid);
                  errors++;
               end
               if (got.gamt !== want.gamt) begin
                  $display("%0t: granted_amount expected %0d actual %0d", $time, want.gamt,
                           got.gamt);
                  errors++;
               end
               if (got.free !== want.free) begin
                  $display("%0t: free_units expected %0d actual %0d", $time, want.free, got.free);
                  errors++;
               end
               if (got.waiting !== want.waiting) begin
                  $display("%0t: waiting_count expected %0d actual %0d", $time, want.waiting,
                           got.waiting);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send(input pwca_pkg::op_type op, input logic [7:0] id,
                       input logic [15:0] amount,
                       input logic [7:0] sprio, input logic [7:0] gprio,
                       input bit typed, input outcome_type outcome);
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {gprio, sprio, amount, id};
      cur_typed = typed;
      cur_outcome = outcome;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic pace();
      int idle;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (idle) @(negedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   function automatic logic [7:0] draw_priority();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
   endfunction

   task automatic random_item();
      pwca_pkg::op_type op;
      logic [15:0]      amount;
      int               room;
      int               pick;
      room = int'(pool_total) - int'(pool_free);
      pick = $urandom_range(0, 99);
      op = (pick < ((waiters.size() >= 12) ? 60 : 40)) ? pwca_pkg::OP_RELEASE
                                                       : pwca_pkg::OP_REQUEST;
      if (op == pwca_pkg::OP_RELEASE) begin
         amount = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, room));
      end else begin
         case ($urandom_range(0, 9))
            0: amount = 16'($urandom);
            1: amount = 16'd0;
            default: amount = 16'($urandom_range(1, int'(pool_total) / 3 + 1));
         endcase
      end
      send(op, 8'($urandom), amount, draw_priority(), draw_priority(), 1'b0, '0);
   endtask

   task automatic set_capacity(input logic [15:0] value);
      req_tvalid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      int  mode;
      int  cycle;
      bit  long_done;
      rsp_tready = 1'b0;
      mode = 0;
      cycle = 0;
      long_done = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (!long_done && responses >= 150) begin
            long_done = 1'b1;
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
         end
         if (cycle % 48 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            2: rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = ((cycle / 3) % 2 == 0);
         endcase
      end
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = pwca_pkg::OP_REQUEST;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cur_typed = 1'b0;
      cur_outcome = '0;
      errors = 0;
      responses = 0;
      burst_left = 0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[r]) begin
         repeat (directed_rows[r].repeats) begin
            send(directed_rows[r].op, directed_rows[r].id, directed_rows[r].amount,
                 directed_rows[r].sprio, directed_rows[r].gprio,
                 directed_rows[r].typed, directed_rows[r].outcome);
            pace();
         end
      end
      for (int p = 0; p < PHASES; p++) begin
         set_capacity((PHASE_CAPACITY[p] == 16'd0) ? 16'($urandom_range(1, 65535))
                                                   : PHASE_CAPACITY[p]);
         repeat (RANDOM_ITEMS / PHASES) begin
            random_item();
            pace();
         end
      end
      req_tvalid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
hdl/pwca_pkg.sv
hdl/pwca_wait_mem.sv
hdl/priority_wait_capacity_allocator.sv
hdl/pwca_checker.sv
tb/tb_priority_wait_capacity_allocator.sv
